>>> hdl/iss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer sequence statistics package
// Widths, constants and the queue entry type shared by the front and back.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int SUM_WIDTH   = 64;
  // Largest magnitude is 2^(VALUE_WIDTH-1), which needs VALUE_WIDTH bits.
  localparam int MAG_WIDTH   = VALUE_WIDTH;
  localparam int RADIX       = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  // Division by ten as a reciprocal multiply: (x * RECIP_10) >> RECIP_SHIFT
  // is exact for every x below 2^32, so it covers any MAG_WIDTH up to 32.
  localparam int               RECIP_WIDTH = 64;
  localparam logic [31:0]      RECIP_10    = 32'hcccccccd;
  localparam int               RECIP_SHIFT = 35;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Command kinds carried from front to back.
  typedef enum logic {
    CMD_VALUE = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // One entry of the queue between the front and the back.
  typedef struct packed {
    cmd_t                         cmd;
    logic                         neg;
    logic [MAG_WIDTH-1:0]         mag;
    logic signed [SUM_WIDTH-1:0]  ext;
  } entry_t;

  // Saturating increment.
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

>>> hdl/integer_sequence_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer sequence statistics core
// Gathers sum and class counts over a zero-terminated sequence of integers.
// ----------------------------------------------------------------------------
// Channel  | Handshake   | Payload
// input    | push, full  | value
// result   | pop, empty  | empty_res, total_count, total_sum, even_count,
//          |             | odd_count, prime_count, even_digit_sum_count,
//          |             | palindrome_count
//
// A non-zero item is reduced one decimal digit at a time and then, if it
// may be prime, tested by trial division up to its square root, one divisor
// at a time, on a sequential divider.
// Reset clears the queue, the totals and the result valid flag.
// A two-entry queue lets input be pushed while the back is busy; a waiting
// result blocks only the next zero.
module integer_sequence_statistics_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [iss_pkg::VALUE_WIDTH-1:0]  value,
  output logic                                    empty,
  input  logic                                    pop,
  output logic                                    empty_res,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         total_count,
  output logic signed [iss_pkg::SUM_WIDTH-1:0]    total_sum,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         even_count,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         odd_count,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         prime_count,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         even_digit_sum_count,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         palindrome_count
);

  logic            q_valid;
  logic            q_take;
  logic            res_valid;
  iss_pkg::entry_t q_entry;

  // Front: accept and classify.
  iss_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .value   (value),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_take  (q_take)
  );

  // Back: tests and totals.
  iss_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (q_valid),
    .q_entry              (q_entry),
    .q_take               (q_take),
    .res_valid            (res_valid),
    .res_take             (pop),
    .empty_res            (empty_res),
    .total_count          (total_count),
    .total_sum            (total_sum),
    .even_count           (even_count),
    .odd_count            (odd_count),
    .prime_count          (prime_count),
    .even_digit_sum_count (even_digit_sum_count),
    .palindrome_count     (palindrome_count)
  );

  assign empty = !res_valid;

endmodule

>>> hdl/iss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer sequence statistics front
// Accepts items, classifies them as value or flush, and queues them.
// ----------------------------------------------------------------------------
module iss_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [iss_pkg::VALUE_WIDTH-1:0] value,
  output logic                              q_valid,
  output iss_pkg::entry_t                   q_entry,
  input  logic                              q_take
);

  iss_pkg::entry_t                         mem [iss_pkg::QUEUE_DEPTH];
  logic [iss_pkg::QUEUE_AW-1:0]            wr_ptr;
  logic [iss_pkg::QUEUE_AW-1:0]            rd_ptr;
  logic [iss_pkg::QUEUE_AW:0]              fill;
  iss_pkg::entry_t                         entry_in;
  logic                                    do_push;
  logic                                    do_pop;

  // Classify the incoming item.
  always_comb begin
    entry_in.neg = value[iss_pkg::VALUE_WIDTH-1];
    entry_in.cmd = (value == '0) ? iss_pkg::CMD_FLUSH : iss_pkg::CMD_VALUE;
    entry_in.ext = iss_pkg::SUM_WIDTH'(value);
    entry_in.mag = entry_in.neg ? iss_pkg::MAG_WIDTH'(-value) : iss_pkg::MAG_WIDTH'(value);
  end

  assign full    = (fill == iss_pkg::QUEUE_DEPTH);
  assign q_valid = (fill != '0);
  assign q_entry = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (iss_pkg::QUEUE_AW+1)'(do_push) - (iss_pkg::QUEUE_AW+1)'(do_pop);
    end
  end

endmodule

>>> hdl/iss_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer sequence statistics divider
// Restoring divider, one quotient bit per cycle; only the remainder is used.
// ----------------------------------------------------------------------------
module iss_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [iss_pkg::MAG_WIDTH-1:0]     dividend,
  input  logic [iss_pkg::MAG_WIDTH-1:0]     divisor,
  output logic                              done,
  output logic [iss_pkg::MAG_WIDTH-1:0]     remainder
);

  localparam int CW = $clog2(iss_pkg::MAG_WIDTH + 1);

  logic [CW-1:0]                    count;
  logic                             busy;
  logic [iss_pkg::MAG_WIDTH-1:0]    dvsr;
  logic [iss_pkg::MAG_WIDTH-1:0]    quotient;
  logic [iss_pkg::MAG_WIDTH:0]      trial;
  logic [iss_pkg::MAG_WIDTH:0]      shifted;

  assign shifted = {remainder, quotient[iss_pkg::MAG_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvsr};

  // Shift and subtract one bit each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        count     <= CW'(iss_pkg::MAG_WIDTH);
        quotient  <= dividend;
        remainder <= '0;
        dvsr      <= divisor;
      end else if (busy) begin
        if (!trial[iss_pkg::MAG_WIDTH]) begin
          remainder <= trial[iss_pkg::MAG_WIDTH-1:0];
          quotient  <= {quotient[iss_pkg::MAG_WIDTH-2:0], 1'b1};
        end else begin
          remainder <= shifted[iss_pkg::MAG_WIDTH-1:0];
          quotient  <= {quotient[iss_pkg::MAG_WIDTH-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/iss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer sequence statistics back
// Runs the digit, palindrome and prime tests and keeps the totals.
// ----------------------------------------------------------------------------
module iss_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  input  iss_pkg::entry_t                         q_entry,
  output logic                                    q_take,
  output logic                                    res_valid,
  input  logic                                    res_take,
  output logic                                    empty_res,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         total_count,
  output logic signed [iss_pkg::SUM_WIDTH-1:0]    total_sum,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         even_count,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         odd_count,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         prime_count,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         even_digit_sum_count,
  output logic [iss_pkg::COUNT_WIDTH-1:0]         palindrome_count
);

  localparam int MW = iss_pkg::MAG_WIDTH;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIGIT  = 6'b000010,
    ST_DWAIT  = 6'b000100,
    ST_PRIME  = 6'b001000,
    ST_PWAIT  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t                          state;
  logic [MW-1:0]                   mag;
  logic [MW-1:0]                   rest;
  logic [MW+3:0]                   rev;
  logic                            dsum_par;
  logic                            neg;
  logic [MW-1:0]                   dvsr;
  logic [2*MW-1:0]                 dsq;
  logic                            is_prime;

  logic [iss_pkg::COUNT_WIDTH-1:0] seen_count;
  logic signed [iss_pkg::SUM_WIDTH-1:0] running_sum;
  logic [iss_pkg::COUNT_WIDTH-1:0] evens_seen;
  logic [iss_pkg::COUNT_WIDTH-1:0] odds_seen;
  logic [iss_pkg::COUNT_WIDTH-1:0] primes_seen;
  logic [iss_pkg::COUNT_WIDTH-1:0] even_digit_sums_seen;
  logic [iss_pkg::COUNT_WIDTH-1:0] palindromes_seen;

  logic                            div_start;
  logic                            div_done;
  logic [MW-1:0]                   div_r;
  logic [MW+3:0]                   rev_next;

  logic [iss_pkg::RECIP_WIDTH-1:0] recip_prod;
  logic [MW-1:0]                   dq;
  logic [MW-1:0]                   dq_times_ten;
  logic [3:0]                      digit;

  // Sequential divider for the trial division.
  iss_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (dvsr),
    .done      (div_done),
    .remainder (div_r)
  );

  assign q_take = (state == ST_IDLE) && q_valid &&
                  !(q_entry.cmd == iss_pkg::CMD_FLUSH && res_valid);

  // Digit extraction: the quotient by ten is registered in ST_DIGIT, and the
  // low digit is taken from it in ST_DWAIT.
  assign recip_prod   = iss_pkg::RECIP_WIDTH'(rest) *
                        iss_pkg::RECIP_WIDTH'(iss_pkg::RECIP_10);
  assign dq_times_ten = dq * MW'(iss_pkg::RADIX);
  assign digit        = 4'(rest - dq_times_ten);

  // The reversed number can exceed the magnitude, so it keeps four extra bits
  // and any digit that carries it into them means "not a palindrome".
  assign rev_next = (rev << 3) + (rev << 1) + (MW+4)'(digit);
  assign dsq      = dvsr * dvsr;

  // Start a trial division while the item may still be prime and the divisor squared is within the magnitude.
  always_comb begin
    case (state)
      ST_PRIME: begin
        div_start = (dsq <= {{MW{1'b0}}, mag}) && is_prime;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Sequencer and totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      res_valid            <= 1'b0;
      seen_count           <= '0;
      running_sum          <= '0;
      evens_seen           <= '0;
      odds_seen            <= '0;
      primes_seen          <= '0;
      even_digit_sums_seen <= '0;
      palindromes_seen     <= '0;
    end else begin
      if (res_valid && res_take) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_take) begin
            if (q_entry.cmd == iss_pkg::CMD_FLUSH) begin
              res_valid            <= 1'b1;
              empty_res            <= (seen_count == '0);
              total_count          <= seen_count;
              total_sum            <= running_sum;
              even_count           <= evens_seen;
              odd_count            <= odds_seen;
              prime_count          <= primes_seen;
              even_digit_sum_count <= even_digit_sums_seen;
              palindrome_count     <= palindromes_seen;
              seen_count           <= '0;
              running_sum          <= '0;
              evens_seen           <= '0;
              odds_seen            <= '0;
              primes_seen          <= '0;
              even_digit_sums_seen <= '0;
              palindromes_seen     <= '0;
            end else begin
              mag         <= q_entry.mag;
              rest        <= q_entry.mag;
              neg         <= q_entry.neg;
              rev         <= '0;
              dsum_par    <= 1'b0;
              running_sum <= running_sum + q_entry.ext;
              seen_count  <= iss_pkg::sat_inc(seen_count);
              if (q_entry.mag[0]) odds_seen  <= iss_pkg::sat_inc(odds_seen);
              else                evens_seen <= iss_pkg::sat_inc(evens_seen);
              state <= ST_DIGIT;
            end
          end
        end
        ST_DIGIT: begin
          dq    <= MW'(recip_prod >> iss_pkg::RECIP_SHIFT);
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          dsum_par <= dsum_par ^ digit[0];
          rev      <= rev_next;
          rest     <= dq;
          if (dq == '0) begin
            if (!(dsum_par ^ digit[0]))
              even_digit_sums_seen <= iss_pkg::sat_inc(even_digit_sums_seen);
            if (rev_next == (MW+4)'(mag))
              palindromes_seen <= iss_pkg::sat_inc(palindromes_seen);
            dvsr     <= MW'(2);
            is_prime <= !neg && (mag >= MW'(2));
            state    <= ST_PRIME;
          end else if (rev_next[MW+3:MW] != '0) begin
            // Too many digits to match the magnitude; keep reducing for the
            // digit sum but poison the reverse.
            rev   <= {4'hf, {MW{1'b0}}};
            state <= ST_DIGIT;
          end else begin
            state <= ST_DIGIT;
          end
        end
        ST_PRIME: begin
          if (div_start) state <= ST_PWAIT;
          else begin
            if (is_prime) primes_seen <= iss_pkg::sat_inc(primes_seen);
            state <= ST_FINISH;
          end
        end
        ST_PWAIT: begin
          if (div_done) begin
            if (div_r == '0) is_prime <= 1'b0;
            dvsr  <= dvsr + 1'b1;
            state <= ST_PRIME;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/iss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer sequence statistics checker
// Port-level checks bound to the core.
// ----------------------------------------------------------------------------
module iss_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   push,
  input logic                                   full,
  input logic                                   empty,
  input logic                                   pop,
  input logic                                   empty_res,
  input logic [iss_pkg::COUNT_WIDTH-1:0]        total_count,
  input logic [iss_pkg::COUNT_WIDTH-1:0]        even_count,
  input logic [iss_pkg::COUNT_WIDTH-1:0]        odd_count
);

  // A held result does not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(total_count))
    else $error("result changed while held");

  // The empty flag matches a zero count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (empty_res == (total_count == '0)))
    else $error("empty flag disagrees with count");

  // Neither the even nor the odd count exceeds the total.
  a_split: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (even_count <= total_count && odd_count <= total_count))
    else $error("class count above total");

  // After reset nothing is waiting and the queue is open.
  a_reset: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("bad state after reset");

endmodule

bind integer_sequence_statistics_core iss_checker u_iss_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .empty_res   (empty_res),
  .total_count (total_count),
  .even_count  (even_count),
  .odd_count   (odd_count)
);
